/* sv/ecfr_pkg.sv */
package ecfr_pkg;

  localparam int unsigned MAX_FRAMES   = 64;
  localparam int unsigned FRAME_W      = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W        = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CLOCK_PASSES = 4;
  localparam int unsigned PASS_W       = $clog2(CLOCK_PASSES);

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_SWAP    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] idx;
    logic               set_in_use;
    logic               clr_in_use;
    logic               set_use;
    logic               clr_use;
    logic               set_mod;
    logic               clr_mod;
  } fs_wr_t;

  typedef struct packed {
    logic in_use;
    logic use_bit;
    logic mod_bit;
  } fs_rd_t;

endpackage

/* sv/ecfr_frame_state.sv */
module ecfr_frame_state
  import ecfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [FRAME_W-1:0] rd_idx,
  output fs_rd_t             rd,
  input  fs_wr_t             wr
);

  logic [MAX_FRAMES-1:0] in_use_r;
  logic [MAX_FRAMES-1:0] use_r;
  logic [MAX_FRAMES-1:0] mod_r;

  assign rd.in_use  = in_use_r[rd_idx];
  assign rd.use_bit = use_r[rd_idx];
  assign rd.mod_bit = mod_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      use_r    <= '0;
      mod_r    <= '0;
    end else if (wr.en) begin
      if (wr.set_in_use) begin
        in_use_r[wr.idx] <= 1'b1;
      end else if (wr.clr_in_use) begin
        in_use_r[wr.idx] <= 1'b0;
      end
      if (wr.set_use) begin
        use_r[wr.idx] <= 1'b1;
      end else if (wr.clr_use) begin
        use_r[wr.idx] <= 1'b0;
      end
      if (wr.set_mod) begin
        mod_r[wr.idx] <= 1'b1;
      end else if (wr.clr_mod) begin
        mod_r[wr.idx] <= 1'b0;
      end
    end
  end

endmodule

/* sv/enhanced_clock_frame_replacer_core.sv */
// Enhanced second-chance clock frame replacer.
// Input channel (in_valid/in_stall): one request carries in_mode and
// in_frame_index. Allocate grants the lowest free frame, or evicts a victim
// chosen by enhanced clock; swap-in always picks a clock victim; release
// frees a frame and echoes its index. Result channel (out_valid/out_stall)
// returns out_chosen_frame and out_evicted, one result per request.
// cfg_we/cfg_wdata set the active frame count; write only while idle.
// Release and the unused mode go straight to the finish state, which loads
// the output register once it is free. Allocate scans one frame per cycle
// from frame 0 for the lowest free frame; a full table then runs the clock,
// one frame a cycle. The second pass clears every use bit it passes, so a
// later pass always finds a victim.
// One request is processed at a time; in_stall is high while it is in
// flight and drops as its result is loaded into the output register.
// A finished result sits in the output register; the next request may be
// taken while it waits, and its own result holds until out_stall drops.
// Reset clears all in-use, use and modified bits, the hand and out_valid,
// and sets the frame count to 64.
module enhanced_clock_frame_replacer_core
  import ecfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [FRAME_W-1:0] in_frame_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAME_W-1:0] out_chosen_frame,
  output logic               out_evicted,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_CLOCK,
    ST_FALLBACK,
    ST_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [FRAME_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PASS_W-1:0]  pass_r, pass_nxt;
  logic [FRAME_W-1:0] hand_r, hand_nxt;
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic               res_ev_r, res_ev_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [CNT_W-1:0]   frame_count_r;

  logic [CNT_W-1:0]   n_eff;
  logic [FRAME_W-1:0] start_idx;
  logic [FRAME_W-1:0] next_idx;
  logic               at_last;
  logic               cnt_last;
  logic               match;
  logic               in_acc;
  fs_rd_t             fs_rd;
  fs_wr_t             fs_wr;

  ecfr_frame_state u_frame_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (idx_r),
    .rd     (fs_rd),
    .wr     (fs_wr)
  );

  always_comb begin
    if (frame_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (frame_count_r > CNT_W'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = frame_count_r;
    end
  end

  assign start_idx = ({1'b0, hand_r} < n_eff) ? hand_r : '0;
  assign at_last   = ({1'b0, idx_r} + CNT_W'(1)) >= n_eff;
  assign next_idx  = at_last ? '0 : idx_r + FRAME_W'(1);
  assign cnt_last  = (cnt_r + CNT_W'(1)) >= n_eff;
  assign match     = !fs_rd.use_bit && (fs_rd.mod_bit == pass_r[0]);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    hand_nxt      = hand_r;
    res_frame_nxt = res_frame_r;
    res_ev_nxt    = res_ev_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_frame_nxt = out_frame_r;
    out_ev_nxt    = out_ev_r;
    fs_wr         = '0;
    fs_wr.idx     = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_mode;
          idx_nxt  = '0;
          cnt_nxt  = '0;
          pass_nxt = '0;
          case (in_mode)
            MODE_ALLOC: begin
              state_nxt = ST_FREE;
            end
            MODE_SWAP: begin
              idx_nxt   = start_idx;
              state_nxt = ST_CLOCK;
            end
            MODE_RELEASE: begin
              fs_wr.en         = 1'b1;
              fs_wr.idx        = in_frame_index;
              fs_wr.clr_in_use = 1'b1;
              res_frame_nxt    = in_frame_index;
              res_ev_nxt       = 1'b0;
              state_nxt        = ST_FINISH;
            end
            default: begin
              res_frame_nxt = '0;
              res_ev_nxt    = 1'b0;
              state_nxt     = ST_FINISH;
            end
          endcase
        end
      end
      ST_FREE: begin
        if (!fs_rd.in_use) begin
          fs_wr.en         = 1'b1;
          fs_wr.set_in_use = 1'b1;
          fs_wr.set_use    = 1'b1;
          fs_wr.set_mod    = 1'b1;
          res_frame_nxt    = idx_r;
          res_ev_nxt       = 1'b0;
          state_nxt        = ST_FINISH;
        end else if (at_last) begin
          idx_nxt   = start_idx;
          state_nxt = ST_CLOCK;
        end else begin
          idx_nxt = next_idx;
        end
      end
      ST_CLOCK: begin
        if (match) begin
          fs_wr.en      = 1'b1;
          fs_wr.set_use = (mode_r == MODE_ALLOC);
          fs_wr.set_mod = (mode_r == MODE_ALLOC);
          fs_wr.clr_mod = (mode_r != MODE_ALLOC);
          hand_nxt      = next_idx;
          res_frame_nxt = idx_r;
          res_ev_nxt    = 1'b1;
          state_nxt     = ST_FINISH;
        end else begin
          // odd passes strip the second chance
          fs_wr.en      = pass_r[0];
          fs_wr.clr_use = pass_r[0];
          idx_nxt       = next_idx;
          if (cnt_last) begin
            cnt_nxt  = '0;
            pass_nxt = pass_r + PASS_W'(1);
            if (pass_r == PASS_W'(CLOCK_PASSES - 1)) begin
              state_nxt = ST_FALLBACK;
            end
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_FALLBACK: begin
        fs_wr.en      = 1'b1;
        fs_wr.idx     = '0;
        fs_wr.set_use = (mode_r == MODE_ALLOC);
        fs_wr.set_mod = (mode_r == MODE_ALLOC);
        fs_wr.clr_mod = (mode_r != MODE_ALLOC);
        res_frame_nxt = '0;
        res_ev_nxt    = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = res_frame_r;
          out_ev_nxt    = res_ev_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_ALLOC;
      idx_r         <= '0;
      cnt_r         <= '0;
      pass_r        <= '0;
      hand_r        <= '0;
      out_valid_r   <= 1'b0;
      frame_count_r <= CNT_W'(MAX_FRAMES);
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_frame_r <= res_frame_nxt;
    res_ev_r    <= res_ev_nxt;
    out_frame_r <= out_frame_nxt;
    out_ev_r    <= out_ev_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_frame = out_frame_r;
  assign out_evicted      = out_ev_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_clock_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOCK) |-> (mode_r == MODE_ALLOC || mode_r == MODE_SWAP))
    else $error("clock scan running for a mode without victim selection");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOCK || state_r == ST_FREE) |-> ({1'b0, idx_r} < n_eff))
    else $error("scan index beyond active frame count");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("finished request did not reach the output register");

endmodule
